FILE: src/grm3_pkg.sv
// ----------------------------------------------------------------------------
// grm3_pkg
// shared types and constants of the 3x3 grey-level morphology core
// ----------------------------------------------------------------------------
package grm3_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // item kinds carried in tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam int PIX_W = 8;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // control of the item sitting in the window stage
    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pix;
        logic             emit;
        logic             inner;
        logic             last;
        logic             fwd;
    } t_win_item;

endpackage

FILE: src/grey_morphology_3x3_core.sv
// ----------------------------------------------------------------------------
// grey_morphology_3x3_core
// 3x3 grey-level erosion / dilation over a raster pixel stream
// path: a result reaches the output register from the item that releases it
//   through the line memory read, then the window and min/max
// throughput: one item per cycle while the skid is empty and the divider idle,
//   set by the read-modify-write of the line memory; a frame_width write holds
//   the input while the bit-serial divider re-derives the position
// reset: synchronous, active low; clears counters, window and registers to
//   their defaults; the line memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module grey_morphology_3x3_core #(
    parameter int MAX_WIDTH  = grm3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = grm3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [grm3_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_in
    input  logic [0:0]                       s_axis_tuser,  // [0] kind
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [grm3_pkg::PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
    output logic                             m_axis_tlast,  // frame_last
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [grm3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [grm3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PW  = $clog2(MAX_WIDTH + 2);
    localparam int DCW = $clog2(CW + 1);
    localparam int LW  = 2 * grm3_pkg::PIX_W;

    function automatic int unsigned clamp_size(
        input logic [grm3_pkg::CFG_DATA_W-1:0] v,
        input int unsigned                     maxv
    );
        int unsigned r;
        r = 32'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic logic [grm3_pkg::PIX_W-1:0] pick2(
        input logic                       m,
        input logic [grm3_pkg::PIX_W-1:0] a,
        input logic [grm3_pkg::PIX_W-1:0] b
    );
        logic [grm3_pkg::PIX_W-1:0] r;
        if (m == grm3_pkg::MODE_DILATE) begin
            r = (a > b) ? a : b;
        end else begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

    // configuration
    logic                            r_mode;
    logic [grm3_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [grm3_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic [WW-1:0]                   w_eff;
    logic [HW-1:0]                   h_eff;

    // position state
    logic [XW-1:0] r_in_col, n_in_col;
    logic [YW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_count, n_out_count;
    logic [CW-1:0] r_out_row, n_out_row;
    logic [XW-1:0] r_out_col, n_out_col;
    logic [PW-1:0] r_pending, n_pending;

    // position divider
    logic           r_busy;
    logic [DCW-1:0] r_div_cnt;
    logic [CW-1:0]  r_div_q;
    logic [WW-1:0]  r_div_rem;
    logic [WW-1:0]  r_div_d;
    logic [WW:0]    div_sh;
    logic           div_ge;
    logic [WW-1:0]  div_rem_nx;
    logic [CW-1:0]  div_q_nx;

    // line memory: low byte is row y-2, high byte row y-1
    logic [LW-1:0] r_line [MAX_WIDTH];
    logic [LW-1:0] r_rd_data;
    logic          rd_en;
    logic [XW-1:0] rd_addr;
    logic          wr_en;
    logic [XW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    // window stage
    logic                   r_s1_valid;
    grm3_pkg::t_win_item    r_s1, n_s1;
    logic [XW-1:0]          r_s1_addr;
    logic [LW-1:0]          r_s1_fwd_data;
    logic                   s0_go;

    logic [grm3_pkg::PIX_W-1:0] r_win   [3][3];
    logic [grm3_pkg::PIX_W-1:0] win_new [3][3];
    logic [grm3_pkg::PIX_W-1:0] col_new [3];
    logic [LW-1:0]              s1_src;
    logic [grm3_pkg::PIX_W-1:0] lvl1 [4];
    logic [grm3_pkg::PIX_W-1:0] lvl2 [2];
    logic [grm3_pkg::PIX_W-1:0] win_pick;
    logic [grm3_pkg::PIX_W-1:0] s1_value;
    logic                       produce;

    // output register and skid
    logic                       r_out_valid;
    logic [grm3_pkg::PIX_W-1:0] r_out_data;
    logic                       r_out_last;
    logic                       r_skid_valid;
    logic [grm3_pkg::PIX_W-1:0] r_skid_data;
    logic                       r_skid_last;

    logic en;
    logic accept;
    logic cfg_wr;

    assign w_eff = WW'(clamp_size(r_frame_width, MAX_WIDTH));
    assign h_eff = HW'(clamp_size(r_frame_height, MAX_HEIGHT));

    assign en            = !r_skid_valid;
    assign s_axis_tready = en && !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= grm3_pkg::MODE_ERODE;
            r_frame_width  <= grm3_pkg::RST_FRAME_WIDTH;
            r_frame_height <= grm3_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                grm3_pkg::REG_MODE:         r_mode         <= i_cfg_data[0];
                grm3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                grm3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input stage: counters, line memory address, window stage control
    // ------------------------------------------------------------------
    always_comb begin
        logic [XW-1:0] icol;
        logic [YW-1:0] irow;
        logic [XW-1:0] ocol;
        logic [CW-1:0] orow;
        logic [CW-1:0] ocnt;
        logic          advance;

        // counters that reach the current size wrap first
        if (32'(r_out_row) >= 32'(h_eff)) begin
            ocol = '0;
            orow = '0;
            ocnt = '0;
        end else begin
            ocol = r_out_col;
            orow = r_out_row;
            ocnt = r_out_count;
        end
        icol = (32'(r_in_col) >= 32'(w_eff)) ? '0 : r_in_col;
        irow = (32'(r_in_row) >= 32'(h_eff)) ? '0 : r_in_row;

        n_in_col    = icol;
        n_in_row    = irow;
        n_pending   = r_pending;
        advance     = 1'b0;
        s0_go       = 1'b1;
        rd_addr     = icol;

        n_s1.kind  = s_axis_tuser[0];
        n_s1.pix   = s_axis_tdata;
        n_s1.emit  = 1'b0;
        n_s1.inner = (orow >= CW'(1)) && (32'(orow) + 2 <= 32'(h_eff)) &&
                     (ocol >= XW'(1)) && (32'(ocol) + 2 <= 32'(w_eff));
        n_s1.last  = (32'(orow) + 1 == 32'(h_eff)) && (32'(ocol) + 1 == 32'(w_eff));
        n_s1.fwd   = wr_en && (wr_addr == rd_addr);

        if (s_axis_tuser[0] == grm3_pkg::KIND_PIXEL) begin
            if (32'(icol) + 1 >= 32'(w_eff)) begin
                n_in_col = '0;
                n_in_row = (32'(irow) + 1 >= 32'(h_eff)) ? '0 : YW'(irow + 1'b1);
            end else begin
                n_in_col = XW'(icol + 1'b1);
            end
            if (32'(r_pending) < 32'(w_eff) + 1) begin
                n_pending = PW'(r_pending + 1'b1);
            end else begin
                advance = 1'b1;
            end
        end else begin
            // flush reads the column right of the next result's centre
            rd_addr = (32'(ocol) + 1 >= 32'(w_eff)) ? '0 : XW'(ocol + 1'b1);
            if (r_pending == '0) begin
                s0_go = 1'b0;
            end else begin
                n_pending = PW'(r_pending - 1'b1);
                advance   = 1'b1;
            end
        end
        n_s1.fwd  = wr_en && (wr_addr == rd_addr);
        n_s1.emit = advance;

        n_out_col   = ocol;
        n_out_row   = orow;
        n_out_count = ocnt;
        if (advance) begin
            if (n_s1.last) begin
                n_out_col   = '0;
                n_out_row   = '0;
                n_out_count = '0;
            end else if (32'(ocol) + 1 == 32'(w_eff)) begin
                n_out_col   = '0;
                n_out_row   = CW'(orow + 1'b1);
                n_out_count = CW'(ocnt + 1'b1);
            end else begin
                n_out_col   = XW'(ocol + 1'b1);
                n_out_count = CW'(ocnt + 1'b1);
            end
        end
    end

    assign rd_en = accept && s0_go;

    // one restoring division step: out_count / width gives row and column
    assign div_sh     = {r_div_rem, r_div_q[CW-1]};
    assign div_ge     = div_sh >= {1'b0, r_div_d};
    assign div_rem_nx = div_ge ? WW'(div_sh - {1'b0, r_div_d}) : WW'(div_sh);
    assign div_q_nx   = {r_div_q[CW-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_count <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_pending   <= '0;
            r_busy      <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (cfg_wr && (i_cfg_index == grm3_pkg::REG_FRAME_WIDTH)) begin
                r_busy    <= 1'b1;
                r_div_cnt <= DCW'(CW);
            end else if (r_busy) begin
                r_div_cnt <= DCW'(r_div_cnt - 1'b1);
                if (r_div_cnt == DCW'(1)) begin
                    r_busy    <= 1'b0;
                    r_out_row <= div_q_nx;
                    r_out_col <= XW'(div_rem_nx);
                end
            end else if (accept) begin
                r_in_col    <= n_in_col;
                r_in_row    <= n_in_row;
                r_out_count <= n_out_count;
                r_out_row   <= n_out_row;
                r_out_col   <= n_out_col;
                r_pending   <= n_pending;
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (cfg_wr && (i_cfg_index == grm3_pkg::REG_FRAME_WIDTH)) begin
            r_div_q   <= r_out_count;
            r_div_rem <= '0;
            r_div_d   <= WW'(clamp_size(i_cfg_data, MAX_WIDTH));
        end else if (r_busy) begin
            r_div_q   <= div_q_nx;
            r_div_rem <= div_rem_nx;
        end
    end

    // ------------------------------------------------------------------
    // line memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_line[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // window stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1          <= n_s1;
            r_s1_addr     <= rd_addr;
            r_s1_fwd_data <= wr_data;
        end
    end

    // a write to the column being read in the same cycle is forwarded
    assign s1_src = r_s1.fwd ? r_s1_fwd_data : r_rd_data;

    always_comb begin
        col_new[0] = s1_src[grm3_pkg::PIX_W-1:0];
        col_new[1] = s1_src[LW-1:grm3_pkg::PIX_W];
        col_new[2] = (r_s1.kind == grm3_pkg::KIND_PIXEL) ? r_s1.pix : '0;
        for (int r = 0; r < 3; r++) begin
            win_new[r][0] = r_win[r][1];
            win_new[r][1] = r_win[r][2];
            win_new[r][2] = col_new[r];
        end
    end

    assign wr_en   = en && r_s1_valid && (r_s1.kind == grm3_pkg::KIND_PIXEL);
    assign wr_addr = r_s1_addr;
    assign wr_data = {r_s1.pix, col_new[1]};

    // min / max tree over the nine window taps
    always_comb begin
        lvl1[0]  = pick2(r_mode, win_new[0][0], win_new[0][1]);
        lvl1[1]  = pick2(r_mode, win_new[0][2], win_new[1][0]);
        lvl1[2]  = pick2(r_mode, win_new[1][1], win_new[1][2]);
        lvl1[3]  = pick2(r_mode, win_new[2][0], win_new[2][1]);
        lvl2[0]  = pick2(r_mode, lvl1[0], lvl1[1]);
        lvl2[1]  = pick2(r_mode, lvl1[2], lvl1[3]);
        win_pick = pick2(r_mode, pick2(r_mode, lvl2[0], lvl2[1]), win_new[2][2]);
        s1_value = r_s1.inner ? win_pick : win_new[1][1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (en && r_s1_valid) begin
            r_win <= win_new;
        end
    end

    assign produce = en && r_s1_valid && r_s1.emit;

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end else if (produce) begin
                r_out_data <= s1_value;
                r_out_last <= r_s1.last;
            end
        end else if (produce) begin
            r_skid_data <= s1_value;
            r_skid_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
